/* rtl/detx_pkg.sv */
// shared types, codes and helpers for the dle/etx frame deframer
`timescale 1ns / 1ps

package detx_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 512;
  localparam int unsigned FIFO_DEPTH       = 4;
  localparam int unsigned CFG_IW           = 2;
  localparam int unsigned CFG_DW           = 64;

  localparam logic [7:0] DLE_CODE = 8'h10;
  localparam logic [7:0] ETX_CODE = 8'h03;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ID_MASK_0_63    = 2'd0,
    CFG_ID_MASK_64_127  = 2'd1,
    CFG_ID_MASK_128_191 = 2'd2,
    CFG_ID_MASK_192_255 = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [9:0] byte_position;
    logic [7:0] frame_tag;
    logic       frame_end;
    logic       frame_abort;
  } detx_result_t;

  typedef struct packed {
    logic not_empty;
    logic room_two;
  } detx_fifo_stat_t;

  function automatic detx_result_t mk_result(logic [7:0] b, logic [9:0] pos, logic [7:0] id,
                                             logic fend, logic fabort);
    detx_result_t r;
    r.frame_byte    = b;
    r.byte_position = pos;
    r.frame_tag     = id;
    r.frame_end     = fend;
    r.frame_abort   = fabort;
    return r;
  endfunction

endpackage

/* rtl/detx_decode.sv */
// per-byte frame decode: next state and up to two results
`timescale 1ns / 1ps

module detx_decode #(
  parameter int unsigned BUFFER_BYTES = detx_pkg::BUFFER_BYTES_DEF,
  parameter int unsigned CW           = $clog2(BUFFER_BYTES + 1)
) (
  input  logic [7:0]                      rx_byte_i,
  input  logic                            id_ok_i,
  input  logic                            in_frame_i,
  input  logic                            dle_pend_i,
  input  logic [CW-1:0]                   pos_i,
  input  logic [7:0]                      fid_i,
  output logic                            in_frame_o,
  output logic                            dle_pend_o,
  output logic [CW-1:0]                   pos_o,
  output logic [7:0]                      fid_o,
  output logic [1:0]                      res_cnt_o,
  output detx_pkg::detx_result_t [1:0]    res_o
);

  import detx_pkg::*;

  localparam logic [CW-1:0] LIM = CW'(BUFFER_BYTES);

  function automatic logic [9:0] pos10(logic [CW-1:0] p);
    logic [CW+9:0] w;
    w = {10'd0, p};
    return w[9:0];
  endfunction

  logic [CW-1:0] pos_inc;
  logic [CW-1:0] pos_inc2;
  logic          full;

  assign pos_inc  = pos_i + CW'(1);
  assign pos_inc2 = pos_i + CW'(2);
  assign full     = in_frame_i && (pos_i >= LIM);

  always_comb begin
    in_frame_o = in_frame_i;
    dle_pend_o = 1'b0;
    pos_o      = pos_i;
    fid_o      = fid_i;
    res_cnt_o  = 2'd0;
    res_o      = '0;
    priority if (dle_pend_i && in_frame_i) begin
      res_o[0] = mk_result(DLE_CODE, pos10(pos_i), fid_i, 1'b0, 1'b0);
      priority if (rx_byte_i == DLE_CODE) begin
        res_cnt_o = 2'd1;
        pos_o     = pos_inc;
      end else if (rx_byte_i == ETX_CODE) begin
        res_o[1]   = mk_result(ETX_CODE, pos10(pos_inc), fid_i, 1'b1, 1'b0);
        res_cnt_o  = 2'd2;
        in_frame_o = 1'b0;
        pos_o      = '0;
        fid_o      = '0;
      end else if (pos_inc >= LIM) begin
        res_o[1]   = mk_result(8'd0, 10'd0, fid_i, 1'b0, 1'b1);
        res_cnt_o  = 2'd2;
        in_frame_o = 1'b0;
        pos_o      = '0;
        fid_o      = '0;
      end else begin
        res_o[1]  = mk_result(rx_byte_i, pos10(pos_inc), fid_i, 1'b0, 1'b0);
        res_cnt_o = 2'd2;
        pos_o     = pos_inc2;
      end
    end else if (dle_pend_i && (rx_byte_i != ETX_CODE) && id_ok_i) begin
      // frame start: leading dle and id together
      res_o[0]   = mk_result(DLE_CODE, 10'd0, rx_byte_i, 1'b0, 1'b0);
      res_o[1]   = mk_result(rx_byte_i, 10'd1, rx_byte_i, 1'b0, 1'b0);
      res_cnt_o  = 2'd2;
      in_frame_o = 1'b1;
      pos_o      = CW'(2);
      fid_o      = rx_byte_i;
    end else begin
      if (full) begin
        res_o[0]   = mk_result(8'd0, 10'd0, fid_i, 1'b0, 1'b1);
        res_cnt_o  = 2'd1;
        in_frame_o = 1'b0;
        pos_o      = '0;
        fid_o      = '0;
      end
      if (rx_byte_i == DLE_CODE) begin
        dle_pend_o = 1'b1;
      end else if (in_frame_i && !full) begin
        res_o[0]  = mk_result(rx_byte_i, pos10(pos_i), fid_i, 1'b0, 1'b0);
        res_cnt_o = 2'd1;
        pos_o     = pos_inc;
      end
    end
  end

endmodule

/* rtl/detx_res_fifo.sv */
// result queue: takes up to two results a cycle, hands out one
`timescale 1ns / 1ps

module detx_res_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [1:0]                      push_cnt_i,
  input  detx_pkg::detx_result_t [1:0]    push_data_i,
  input  logic                            pop_i,
  output detx_pkg::detx_result_t          head_o,
  output detx_pkg::detx_fifo_stat_t       stat_o
);

  import detx_pkg::*;

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned NW = $clog2(FIFO_DEPTH + 1);

  detx_result_t mem_q [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] count_q, count_d;
  logic [AW-1:0] wr_ptr_nx1;

  assign wr_ptr_nx1 = wr_ptr_q + AW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + AW'(push_cnt_i);
    rd_ptr_d = pop_i ? rd_ptr_q + AW'(1) : rd_ptr_q;
    count_d  = count_q + NW'(push_cnt_i) - NW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push_data_i[0];
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nx1] <= push_data_i[1];
    end
  end

  assign head_o           = mem_q[rd_ptr_q];
  assign stat_o.not_empty = (count_q != '0);
  assign stat_o.room_two  = (count_q <= NW'(FIFO_DEPTH - 2));

endmodule

/* rtl/dle_etx_frame_deframer.sv */
// dle/etx byte-stuffing deframer top level
//
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   rx_byte_i
// out       output     out_valid_o / out_stall_i frame_byte_o, byte_position_o,
//                                                frame_tag_o, frame_end_o, frame_abort_o
// cfg       input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// one received byte per cycle unless stalled; the decode is a single pass over the frame
// state; a byte yields zero, one or two results into a four-entry result queue that
// drains at most one transaction per cycle, so two-result bytes cost the queue a slot
// in_stall_o rises while the queue holds fewer than two free entries
// reset: hunting for a frame start, every message id accepted, queue empty
`timescale 1ns / 1ps

module dle_etx_frame_deframer #(
  parameter int unsigned BUFFER_BYTES = detx_pkg::BUFFER_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    frame_byte_o,
  output logic [9:0]                    byte_position_o,
  output logic [7:0]                    frame_tag_o,
  output logic                          frame_end_o,
  output logic                          frame_abort_o,
  input  logic                          cfg_we_i,
  input  logic [detx_pkg::CFG_IW-1:0]   cfg_index_i,
  input  logic [detx_pkg::CFG_DW-1:0]   cfg_data_i
);

  import detx_pkg::*;

  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
  localparam logic [CW-1:0] LIM = CW'(BUFFER_BYTES);

  logic [3:0][CFG_DW-1:0] id_mask_q;
  logic [255:0]           id_flat;
  logic                   in_frame_q, in_frame_d, in_frame_nx;
  logic                   dle_pend_q, dle_pend_d, dle_pend_nx;
  logic [CW-1:0]          pos_q, pos_d, pos_nx;
  logic [7:0]             fid_q, fid_d, fid_nx;
  logic [1:0]             res_cnt;
  detx_result_t [1:0]     res;
  detx_result_t           head;
  detx_fifo_stat_t        fifo_stat;
  logic                   in_acc;
  logic                   out_acc;

  assign id_flat    = id_mask_q;
  assign in_stall_o = !fifo_stat.room_two;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_mask_q <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ID_MASK_0_63:    id_mask_q[0] <= cfg_data_i;
        CFG_ID_MASK_64_127:  id_mask_q[1] <= cfg_data_i;
        CFG_ID_MASK_128_191: id_mask_q[2] <= cfg_data_i;
        CFG_ID_MASK_192_255: id_mask_q[3] <= cfg_data_i;
      endcase
    end
  end

  detx_decode #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .CW          (CW)
  ) u_decode (
    .rx_byte_i (rx_byte_i),
    .id_ok_i   (id_flat[rx_byte_i]),
    .in_frame_i(in_frame_q),
    .dle_pend_i(dle_pend_q),
    .pos_i     (pos_q),
    .fid_i     (fid_q),
    .in_frame_o(in_frame_nx),
    .dle_pend_o(dle_pend_nx),
    .pos_o     (pos_nx),
    .fid_o     (fid_nx),
    .res_cnt_o (res_cnt),
    .res_o     (res)
  );

  always_comb begin
    in_frame_d = in_acc ? in_frame_nx : in_frame_q;
    dle_pend_d = in_acc ? dle_pend_nx : dle_pend_q;
    pos_d      = in_acc ? pos_nx : pos_q;
    fid_d      = in_acc ? fid_nx : fid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      dle_pend_q <= 1'b0;
      pos_q      <= '0;
      fid_q      <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      dle_pend_q <= dle_pend_d;
      pos_q      <= pos_d;
      fid_q      <= fid_d;
    end
  end

  detx_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (in_acc ? res_cnt : 2'd0),
    .push_data_i(res),
    .pop_i      (out_acc),
    .head_o     (head),
    .stat_o     (fifo_stat)
  );

  assign out_valid_o     = fifo_stat.not_empty;
  assign frame_byte_o    = head.frame_byte;
  assign byte_position_o = head.byte_position;
  assign frame_tag_o     = head.frame_tag;
  assign frame_end_o     = head.frame_end;
  assign frame_abort_o   = head.frame_abort;

`ifndef SYNTHESIS
  a_frame_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> (pos_q >= CW'(2) && pos_q <= LIM))
    else $error("frame position out of range");

  a_pend_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_frame_q && dle_pend_q) |-> (pos_q < LIM))
    else $error("pending dle at buffer limit");

  a_hunt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> (pos_q == '0 && fid_q == '0))
    else $error("stale frame state while hunting");
`endif

endmodule
